// ===== sv/mtg_pkg.sv =====
`timescale 1ns / 1ps
// Package: constants, types and tempering function for the MT19937 generator.
package mtg_pkg;

    localparam int unsigned MT_WORDS = 624;
    localparam int unsigned MT_SHIFT = 397;
    localparam int unsigned IDX_W    = $clog2(MT_WORDS);
    localparam int unsigned WORD_W   = 32;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MT_WORDS - 1);

    localparam logic [WORD_W-1:0] MT_DEFAULT_SEED = 32'd5489;
    localparam logic [WORD_W-1:0] MT_INIT_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] MT_MATRIX       = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] MT_UPPER        = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MT_LOWER        = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] MT_TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] MT_TEMPER_C     = 32'hefc6_0000;

    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_RESEED = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FILL  = 4'b0010,
        ST_ISSUE = 4'b0100,
        ST_CALC  = 4'b1000
    } mtg_state_t;

    typedef struct packed {
        logic fill_load;   // start a seed fill
        logic use_default; // fill from the default seed instead of the request
        logic fill_run;    // write one seed word, advance the recurrence
        logic issue;       // read the two twist operands
        logic calc;        // twist one word, temper it, write it back
    } mtg_cmd_t;

    typedef struct packed {
        logic fill_done;   // last word of the fill is being written
    } mtg_status_t;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== sv/mtg_req_if.sv =====
`timescale 1ns / 1ps
// Request channel interface: draw or reseed items.
interface mtg_req_if;
    import mtg_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [WORD_W-1:0] seed;

    modport source (output valid, output kind, output seed, input ready);
    modport sink   (input valid, input kind, input seed, output ready);
endinterface

// ===== sv/mtg_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel interface: tempered random words.
interface mtg_rsp_if;
    import mtg_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

// ===== sv/mtg_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: request sequencing, seed fill control, result valid.
module mtg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_kind,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mtg_pkg::mtg_cmd_t    cmd,
    input  mtg_pkg::mtg_status_t status
);
    import mtg_pkg::*;

    mtg_state_t state_reg, state_next;
    logic       seeded_reg, seeded_next;
    logic       pending_reg, pending_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        seeded_next  = seeded_reg;
        pending_next = pending_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == KIND_RESEED)
                    begin
                        cmd.fill_load = 1'b1;
                        seeded_next   = 1'b1;
                        pending_next  = 1'b0;
                        state_next    = ST_FILL;
                    end
                    else if (!seeded_reg)
                    begin
                        // draw with no seed yet: fill from the default seed first
                        cmd.fill_load   = 1'b1;
                        cmd.use_default = 1'b1;
                        seeded_next     = 1'b1;
                        pending_next    = 1'b1;
                        state_next      = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.fill_run = 1'b1;
                if (status.fill_done)
                begin
                    state_next = pending_reg ? ST_ISSUE : ST_IDLE;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue  = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                // hold here until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.calc   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.calc ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seeded_reg    <= 1'b0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/mtg_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: word store, seed recurrence, per-word twist and tempering.
module mtg_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [mtg_pkg::WORD_W-1:0]   seed,
    input  mtg_pkg::mtg_cmd_t            cmd,
    output mtg_pkg::mtg_status_t         status,
    output logic [mtg_pkg::WORD_W-1:0]   random_word
);
    import mtg_pkg::*;

    logic [WORD_W-1:0] mem [MT_WORDS];

    logic [IDX_W-1:0]  fill_idx_reg, fill_idx_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [WORD_W-1:0] fill_word_reg, fill_word_next;
    logic [WORD_W-1:0] cur_reg, cur_next;
    logic [WORD_W-1:0] rd_next_reg;
    logic [WORD_W-1:0] rd_far_reg;
    logic [WORD_W-1:0] out_word_reg;

    logic [WORD_W-1:0] load_word;
    logic [WORD_W-1:0] mix;
    logic [IDX_W-1:0]  fill_idx_inc;
    logic [IDX_W-1:0]  addr_next;
    logic [IDX_W:0]    far_sum;
    logic [IDX_W-1:0]  addr_far;
    logic [WORD_W-1:0] twist_y;
    logic [WORD_W-1:0] twisted;

    assign load_word    = cmd.use_default ? MT_DEFAULT_SEED : seed;
    assign fill_idx_inc = fill_idx_reg + 1'b1;
    assign mix          = fill_word_reg ^ (fill_word_reg >> 30);
    assign status.fill_done = (fill_idx_reg == IDX_LAST);

    // operand addresses for twisting word pos: pos+1 and pos+397, both mod 624
    assign addr_next = (pos_reg == IDX_LAST) ? '0 : pos_reg + 1'b1;
    assign far_sum   = {1'b0, pos_reg} + (IDX_W + 1)'(MT_SHIFT);
    assign addr_far  = (far_sum >= (IDX_W + 1)'(MT_WORDS))
                     ? IDX_W'(far_sum - (IDX_W + 1)'(MT_WORDS))
                     : far_sum[IDX_W-1:0];

    // cur_reg holds the pre-twist value of word pos; words past pos are untouched,
    // words before it are already twisted, as the in-order recurrence needs
    assign twist_y = (cur_reg & MT_UPPER) | (rd_next_reg & MT_LOWER);
    assign twisted = rd_far_reg ^ (twist_y >> 1) ^ (twist_y[0] ? MT_MATRIX : '0);

    always_comb
    begin
        fill_idx_next  = fill_idx_reg;
        fill_word_next = fill_word_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        if (cmd.fill_load)
        begin
            fill_idx_next  = '0;
            fill_word_next = load_word;
            cur_next       = load_word;
            pos_next       = '0;
        end
        else if (cmd.fill_run)
        begin
            fill_idx_next  = fill_idx_inc;
            fill_word_next = MT_INIT_MULT * mix + WORD_W'(fill_idx_inc);
        end
        else if (cmd.calc)
        begin
            cur_next = rd_next_reg;
            pos_next = (pos_reg == IDX_LAST) ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_idx_reg <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            fill_idx_reg <= fill_idx_next;
            pos_reg      <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_word_reg <= fill_word_next;
        cur_reg       <= cur_next;
        if (cmd.calc)
        begin
            out_word_reg <= temper(twisted);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_run)
        begin
            mem[fill_idx_reg] <= fill_word_reg;
        end
        else if (cmd.calc)
        begin
            mem[pos_reg] <= twisted;
        end
        if (cmd.issue)
        begin
            rd_next_reg <= mem[addr_next];
            rd_far_reg  <= mem[addr_far];
        end
    end

    assign random_word = out_word_reg;

endmodule

// ===== sv/mersenne_twister_generator.sv =====
`timescale 1ns / 1ps
// Top level: MT19937 generator, controller plus datapath.
//
//   channel   dir   payload              transfer
//   request   in    kind, seed           one draw or reseed item
//   result    out   random_word          one tempered word per draw
//
// A draw goes from request transfer to result valid through ST_ISSUE, an
// operand read from the 2-read-port word store, and ST_CALC: twist, temper
// and write-back. A reseed fills the 624-word store one word per cycle; a
// draw before any reseed runs that fill with seed 5489 before it.
// The result register frees the request side; a stalled result holds the
// next request only once that request's word is ready. Reset is async, low.
module mersenne_twister_generator (
    input  logic      clk,
    input  logic      rst_n,
    mtg_req_if.sink   request,
    mtg_rsp_if.source result
);
    import mtg_pkg::*;

    mtg_cmd_t    cmd;
    mtg_status_t status;

    mtg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_kind   (request.kind),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .status    (status)
    );

    mtg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed        (request.seed),
        .cmd         (cmd),
        .status      (status),
        .random_word (result.random_word)
    );

endmodule
